FILE: rtl/core/tsrl_pkg.sv
// ----------------------------------------------------------------------------
// tsrl_pkg
// Shared types and constants of the teleop slew rate limiter: opcodes,
// register indexes, register reset values and field widths.
// ----------------------------------------------------------------------------
package tsrl_pkg;

  localparam int CFG_DATA_W = 16;
  localparam int SPEED_W    = 15;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_LINEAR_SPEED  = 3'd0,
    REG_ANGULAR_SPEED = 3'd1,
    REG_LINEAR_STEP   = 3'd2,
    REG_ANGULAR_STEP  = 3'd3,
    REG_TIMEOUT_TICKS = 3'd4,
    REG_STOP_REPEAT   = 3'd5,
    REG_DEADMAN_EN    = 3'd6,
    REG_DEADMAN_IDX   = 3'd7
  } cfg_index_t;

  typedef logic signed [15:0] q_t;
  typedef logic [SPEED_W-1:0] mag_t;

  typedef struct packed {
    mag_t        linear_speed;
    mag_t        angular_speed;
    mag_t        linear_step;
    mag_t        angular_step;
    logic [15:0] timeout_ticks;
    logic [7:0]  stop_repeat_limit;
    logic        deadman_enable;
    logic [3:0]  deadman_index;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    linear_speed:      15'd819,
    angular_speed:     15'd2048,
    linear_step:       15'd123,
    angular_step:      15'd246,
    timeout_ticks:     16'd15,
    stop_repeat_limit: 8'd10,
    deadman_enable:    1'b0,
    deadman_index:     4'd4
  };

endpackage

FILE: rtl/core/tsrl_if.sv
// ----------------------------------------------------------------------------
// tsrl interfaces
// Valid/ready channels for joystick/tick commands and velocity results.
// ----------------------------------------------------------------------------
interface tsrl_cmd_if;
  import tsrl_pkg::*;

  logic        valid;
  logic        ready;
  op_t         opcode;
  q_t          axis_forward;
  q_t          axis_lateral;
  logic [15:0] button_bits;

  modport source (output valid, opcode, axis_forward, axis_lateral, button_bits,
                  input ready);
  modport sink   (input valid, opcode, axis_forward, axis_lateral, button_bits,
                  output ready);
endinterface

interface tsrl_vel_if;
  import tsrl_pkg::*;

  logic valid;
  logic ready;
  q_t   vel_forward;
  q_t   vel_lateral;
  q_t   yaw_rate;
  logic timed_out;

  modport source (output valid, vel_forward, vel_lateral, yaw_rate, timed_out,
                  input ready);
  modport sink   (input valid, vel_forward, vel_lateral, yaw_rate, timed_out,
                  output ready);
endinterface

FILE: rtl/core/teleop_slew_rate_limiter_unit.sv
// ----------------------------------------------------------------------------
// teleop_slew_rate_limiter_unit
// Turns joystick samples into a slew-limited Q3.12 velocity command.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      words
//  cmd      in   valid/ready    joystick sample or control tick
//  vel      out  valid/ready    forward, lateral, yaw command + timeout flag
//  cfg      in   write enable   one register per write, no read-back
//
//  one word per cycle unless vel stalls a result; a tick result reaches vel
//  via the input register, then multiply/clamp/slew into the result register
//  samples and suppressed zero commands leave vel untouched
//  a stalled vel holds the pipe only when the waiting tick has a result
//  rst is synchronous; it clears state and loads the register defaults
// ----------------------------------------------------------------------------
module teleop_slew_rate_limiter_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  tsrl_pkg::cfg_index_t                cfg_index,
  input  logic [tsrl_pkg::CFG_DATA_W-1:0]     cfg_data,
  tsrl_cmd_if.sink                            cmd,
  tsrl_vel_if.source                          vel
);
  import tsrl_pkg::*;

  // symmetric clamp to +/- lim
  function automatic logic signed [17:0] clamp_sym(logic signed [17:0] v, mag_t lim);
    logic signed [17:0] l;
    l = $signed({3'b000, lim});
    if (v > l) begin
      return l;
    end else if (v < -l) begin
      return -l;
    end
    return v;
  endfunction

  function automatic q_t slew(q_t cur, logic signed [17:0] tgt, mag_t step);
    logic signed [17:0] diff;
    logic signed [17:0] res;
    diff = tgt - 18'(cur);
    res  = 18'(cur) + clamp_sym(diff, step);
    return res[15:0];
  endfunction

  // round half up of axis * speed / 2^15
  function automatic logic signed [17:0] scale_axis(q_t axis, mag_t speed);
    logic signed [31:0] prod;
    prod = axis * $signed({1'b0, speed});
    prod = prod + 32'sd16384;
    return 18'($signed(prod[31:15]));
  endfunction

  cfg_t cfg;

  // input register
  logic        s1_valid;
  op_t         s1_opcode;
  q_t          s1_forward;
  q_t          s1_lateral;
  logic [15:0] s1_buttons;

  // block state
  q_t          held_forward;
  q_t          held_lateral;
  logic [15:0] held_buttons;
  logic        sample_seen;
  logic [15:0] ticks_since_sample;
  q_t          out_forward;
  q_t          out_lateral;
  q_t          out_yaw;
  logic [7:0]  zero_repeats;

  // result register
  logic        res_valid;
  q_t          res_forward;
  q_t          res_lateral;
  q_t          res_yaw;
  logic        res_timed_out;

  // next values
  logic [15:0] ticks_next;
  q_t          out_forward_next;
  q_t          out_lateral_next;
  q_t          out_yaw_next;
  logic [7:0]  zero_repeats_next;
  logic        emit;
  logic        timed_out_next;

  logic signed [17:0] tgt_forward;
  logic signed [17:0] tgt_lateral;
  logic signed [17:0] tgt_yaw;
  logic               timeout_hit;
  logic               deadman_off;
  logic               res_free;
  logic               s1_go;
  logic               s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LINEAR_SPEED:  cfg.linear_speed      <= cfg_data[SPEED_W-1:0];
        REG_ANGULAR_SPEED: cfg.angular_speed     <= cfg_data[SPEED_W-1:0];
        REG_LINEAR_STEP:   cfg.linear_step       <= cfg_data[SPEED_W-1:0];
        REG_ANGULAR_STEP:  cfg.angular_step      <= cfg_data[SPEED_W-1:0];
        REG_TIMEOUT_TICKS: cfg.timeout_ticks     <= cfg_data[15:0];
        REG_STOP_REPEAT:   cfg.stop_repeat_limit <= cfg_data[7:0];
        REG_DEADMAN_EN:    cfg.deadman_enable    <= cfg_data[0];
        REG_DEADMAN_IDX:   cfg.deadman_index     <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    ticks_next = (ticks_since_sample == 16'hFFFF) ? ticks_since_sample
                                                  : ticks_since_sample + 16'd1;
    timeout_hit = (cfg.timeout_ticks != 16'd0) && sample_seen &&
                  (ticks_next > cfg.timeout_ticks);
    deadman_off = cfg.deadman_enable && !held_buttons[cfg.deadman_index];

    tgt_forward = scale_axis(held_forward, cfg.linear_speed);
    tgt_lateral = scale_axis(held_lateral, cfg.linear_speed);
    case ({held_buttons[2], held_buttons[1]})
      2'b10:   tgt_yaw = $signed({3'b000, cfg.angular_speed});
      2'b01:   tgt_yaw = -$signed({3'b000, cfg.angular_speed});
      default: tgt_yaw = '0;
    endcase
    if (deadman_off) begin
      tgt_forward = '0;
      tgt_lateral = '0;
      tgt_yaw     = '0;
    end
    tgt_forward = clamp_sym(tgt_forward, cfg.linear_speed);
    tgt_lateral = clamp_sym(tgt_lateral, cfg.linear_speed);
    tgt_yaw     = clamp_sym(tgt_yaw, cfg.angular_speed);

    timed_out_next    = 1'b0;
    zero_repeats_next = zero_repeats;
    emit              = 1'b0;
    if (timeout_hit) begin
      out_forward_next = '0;
      out_lateral_next = '0;
      out_yaw_next     = '0;
      timed_out_next   = 1'b1;
      emit             = 1'b1;
    end else begin
      out_forward_next = slew(out_forward, tgt_forward, cfg.linear_step);
      out_lateral_next = slew(out_lateral, tgt_lateral, cfg.linear_step);
      out_yaw_next     = slew(out_yaw, tgt_yaw, cfg.angular_step);
      if (out_forward_next == '0 && out_lateral_next == '0 && out_yaw_next == '0) begin
        // zero command is repeated only a limited number of times
        if (zero_repeats < cfg.stop_repeat_limit) begin
          zero_repeats_next = zero_repeats + 8'd1;
          emit              = 1'b1;
        end
      end else begin
        zero_repeats_next = '0;
        emit              = 1'b1;
      end
    end
    if (s1_opcode != OP_TICK) begin
      emit = 1'b0;
    end
  end

  assign res_free  = !res_valid || vel.ready;
  assign s1_go     = !emit || res_free;
  assign s1_fire   = s1_valid && s1_go;
  assign cmd.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
    if (cmd.ready) begin
      s1_opcode  <= cmd.opcode;
      s1_forward <= cmd.axis_forward;
      s1_lateral <= cmd.axis_lateral;
      s1_buttons <= cmd.button_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_forward       <= '0;
      held_lateral       <= '0;
      held_buttons       <= '0;
      sample_seen        <= 1'b0;
      ticks_since_sample <= '0;
      out_forward        <= '0;
      out_lateral        <= '0;
      out_yaw            <= '0;
      zero_repeats       <= '0;
    end else if (s1_fire) begin
      if (s1_opcode == OP_SAMPLE) begin
        held_forward       <= s1_forward;
        held_lateral       <= s1_lateral;
        held_buttons       <= s1_buttons;
        sample_seen        <= 1'b1;
        ticks_since_sample <= '0;
      end else begin
        ticks_since_sample <= ticks_next;
        out_forward        <= out_forward_next;
        out_lateral        <= out_lateral_next;
        out_yaw            <= out_yaw_next;
        zero_repeats       <= zero_repeats_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_fire && emit) begin
      res_valid <= 1'b1;
    end else if (vel.ready) begin
      res_valid <= 1'b0;
    end
    if (s1_fire && emit) begin
      res_forward   <= out_forward_next;
      res_lateral   <= out_lateral_next;
      res_yaw       <= out_yaw_next;
      res_timed_out <= timed_out_next;
    end
  end

  assign vel.valid       = res_valid;
  assign vel.vel_forward = res_forward;
  assign vel.vel_lateral = res_lateral;
  assign vel.yaw_rate    = res_yaw;
  assign vel.timed_out   = res_timed_out;

endmodule

FILE: rtl/core/tsrl_checker.sv
// ----------------------------------------------------------------------------
// tsrl_checker
// Port-level checks of the teleop slew rate limiter, bound to the top level.
// ----------------------------------------------------------------------------
module tsrl_checker (
  input logic               clk,
  input logic               rst,
  input logic               cmd_valid,
  input logic               cmd_ready,
  input logic               vel_valid,
  input logic               vel_ready,
  input tsrl_pkg::q_t       vel_forward,
  input tsrl_pkg::q_t       vel_lateral,
  input tsrl_pkg::q_t       yaw_rate,
  input logic               timed_out
);
  import tsrl_pkg::*;

  // a stalled result word stays offered
  a_vel_hold: assert property (@(posedge clk) disable iff (rst)
    vel_valid && !vel_ready |=> vel_valid)
    else $error("vel word dropped while stalled");

  // a timeout always commands a full stop
  a_timeout_zero: assert property (@(posedge clk) disable iff (rst)
    vel_valid && timed_out |-> vel_forward == '0 && vel_lateral == '0 && yaw_rate == '0)
    else $error("timeout word carries nonzero velocity");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !vel_valid)
    else $error("vel valid right after reset");

  // a fresh result needs a command word accepted ahead of it through the input register
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    $rose(vel_valid) |-> $past(cmd_valid && cmd_ready, 2))
    else $error("vel word without an accepted command");

endmodule

bind teleop_slew_rate_limiter_unit tsrl_checker u_tsrl_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd.valid),
  .cmd_ready   (cmd.ready),
  .vel_valid   (vel.valid),
  .vel_ready   (vel.ready),
  .vel_forward (vel.vel_forward),
  .vel_lateral (vel.vel_lateral),
  .yaw_rate    (vel.yaw_rate),
  .timed_out   (vel.timed_out)
);
